>>> design/unsigned_to_decimal_ascii_macros.svh
// assertion macros for the converter rtl
`ifndef UNSIGNED_TO_DECIMAL_ASCII_MACROS_SVH
`define UNSIGNED_TO_DECIMAL_ASCII_MACROS_SVH

// property must hold at every clock edge outside reset
`define U2DA_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define U2DA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/u2da_pkg.sv
// types and constants for the decimal ascii converter
package u2da_pkg;

  localparam int MAX_DIGITS = 10;

  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] ASCII_NINE = 8'd57;
  localparam logic [7:0] ASCII_NUL  = 8'd0;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic [31:0] value;
    logic [7:0]  buffer_size;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic [3:0] position;
    logic       fits;
    logic [3:0] needed_size;
    logic       last;
  } out_item_t;

endpackage

>>> design/u2da_stream_if.sv
// valid/ready stream channel carrying one payload struct per beat
interface u2da_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/unsigned_to_decimal_ascii.sv
// unsigned binary to decimal ascii string converter
//
// din carries one beat per number: value and the size of the destination
// buffer. dout returns the string one character per beat, most significant
// digit first, then a zero terminator; every beat has its position and the
// needed size (digits plus one), last marks the final beat. If the needed
// size exceeds buffer_size a single beat with fits low is sent instead.
// Only the low VALUE_WIDTH bits of value are used (up to 32).
// din.ready is high only while no number is being worked on. A number is
// accepted in idle, converted one binary bit at a time in the shift and
// add-3 binary to bcd unit, then the string is sized and sent at one
// output beat per cycle while the receiver takes them (needed size, at
// most 11, or 1 on failure).
// dout is a register: a stall holds the beat and pauses the emission; the
// next number can be taken once the last beat has been loaded.
// Synchronous reset returns to idle and drops dout.valid.
`include "unsigned_to_decimal_ascii_macros.svh"

module unsigned_to_decimal_ascii #(
  parameter int VALUE_WIDTH = 32
) (
  input logic          clk,
  input logic          rst,
  u2da_stream_if.sink   din,
  u2da_stream_if.source dout
);

  localparam int CONV_W = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int CNT_W  = $clog2(CONV_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CONV_W - 1);
  localparam int BCD_W  = u2da_pkg::MAX_DIGITS * 4;

  typedef enum logic [1:0] {ST_IDLE, ST_CONV, ST_SIZE, ST_EMIT} state_t;

  state_t                 state;
  logic [CONV_W-1:0]      bin;
  u2da_pkg::digit_t       bcd [u2da_pkg::MAX_DIGITS];
  logic [CNT_W-1:0]       cnt;
  logic [7:0]             buf_size;
  logic [3:0]             nd;
  logic [3:0]             need;
  logic                   fits;
  logic [3:0]             pos;
  logic                   out_valid;
  u2da_pkg::out_item_t    out_data;

  u2da_pkg::digit_t       bcd_next [u2da_pkg::MAX_DIGITS];
  logic [BCD_W-1:0]       bcd_flat;
  logic [BCD_W-1:0]       bcd_shift;
  logic [3:0]             nd_calc;
  logic [3:0]             need_calc;
  logic                   fits_calc;
  logic [3:0]             sel;
  u2da_pkg::digit_t       digit_sel;
  logic                   slot_free;
  logic                   beat_load;

  assign din.ready  = (state == ST_IDLE);
  assign dout.valid = out_valid;
  assign dout.data  = out_data;
  assign slot_free  = !out_valid || dout.ready;
  assign beat_load  = (state == ST_EMIT) && slot_free;

  // add 3 to every digit of 5 or more, then shift one binary bit in
  always_comb begin
    for (int i = 0; i < u2da_pkg::MAX_DIGITS; i++) begin
      bcd_flat[4*i +: 4] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
    bcd_shift = {bcd_flat[BCD_W-2:0], bin[CONV_W-1]};
    for (int i = 0; i < u2da_pkg::MAX_DIGITS; i++) begin
      bcd_next[i] = bcd_shift[4*i +: 4];
    end
  end

  // digit count from the highest nonzero bcd digit, zero counts as one digit
  always_comb begin
    nd_calc = 4'd1;
    for (int i = 0; i < u2da_pkg::MAX_DIGITS; i++) begin
      if (bcd[i] != 4'd0) begin
        nd_calc = 4'(i + 1);
      end
    end
    need_calc = nd_calc + 4'd1;
    fits_calc = ({4'd0, need_calc} <= buf_size);
  end

  assign sel       = nd - 4'd1 - pos;
  assign digit_sel = bcd[sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (beat_load) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (din.valid) begin
            bin      <= din.data.value[CONV_W-1:0];
            buf_size <= din.data.buffer_size;
            cnt      <= '0;
            for (int i = 0; i < u2da_pkg::MAX_DIGITS; i++) begin
              bcd[i] <= 4'd0;
            end
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          for (int i = 0; i < u2da_pkg::MAX_DIGITS; i++) begin
            bcd[i] <= bcd_next[i];
          end
          bin <= bin << 1;
          cnt <= cnt + 1'b1;
          if (cnt == CNT_LAST) begin
            state <= ST_SIZE;
          end
        end
        ST_SIZE: begin
          nd    <= nd_calc;
          need  <= need_calc;
          fits  <= fits_calc;
          pos   <= 4'd0;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_data.needed_size <= need;
            out_data.fits        <= fits;
            if (!fits) begin
              out_data.char_code <= u2da_pkg::ASCII_NUL;
              out_data.position  <= 4'd0;
              out_data.last      <= 1'b1;
              state              <= ST_IDLE;
            end else if (pos != nd) begin
              out_data.char_code <= u2da_pkg::ASCII_ZERO + {4'd0, digit_sel};
              out_data.position  <= pos;
              out_data.last      <= 1'b0;
              pos                <= pos + 4'd1;
            end else begin
              out_data.char_code <= u2da_pkg::ASCII_NUL;
              out_data.position  <= nd;
              out_data.last      <= 1'b1;
              state              <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `U2DA_ASSERT(a_fail_single, clk, rst, !(dout.valid && !dout.data.fits) || (dout.data.last && dout.data.char_code == u2da_pkg::ASCII_NUL && dout.data.position == 4'd0), "failure beat must be a lone terminator")
  `U2DA_ASSERT(a_digit_range, clk, rst, !(dout.valid && !dout.data.last) || (dout.data.char_code >= u2da_pkg::ASCII_ZERO && dout.data.char_code <= u2da_pkg::ASCII_NINE), "non-final beat is not a decimal digit")
  `U2DA_ASSERT(a_pos_bound, clk, rst, !dout.valid || (dout.data.position < dout.data.needed_size), "position beyond needed size")
  `U2DA_ASSERT(a_need_range, clk, rst, !dout.valid || (dout.data.needed_size >= 4'd2 && dout.data.needed_size <= 4'd11), "needed size out of range")
  `U2DA_ASSERT_NEXT(a_accept_starts, clk, rst, din.valid && din.ready, state == ST_CONV && !din.ready, "accepted beat did not start a conversion")

endmodule

>>> dv/unsigned_to_decimal_ascii_test.sv
// self-checking testbench for the unsigned to decimal ascii converter
module unsigned_to_decimal_ascii_test;

  localparam int VALUE_WIDTH = 32;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = 60;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 100;

  class char_scoreboard;
    u2da_pkg::out_item_t pending_chars[$];
    int errors;

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    static function int digit_count(logic [31:0] v);
      int nd;
      nd = 0;
      do begin
        nd++;
        v = v / 10;
      end while (v != 0);
      return nd;
    endfunction

    // expected characters for one accepted number
    function void note_input(u2da_pkg::in_item_t it);
      logic [31:0]         v;
      logic [3:0]          digs[u2da_pkg::MAX_DIGITS];
      int                  nd;
      int                  need;
      u2da_pkg::out_item_t r;
      v = it.value;
      if (VALUE_WIDTH < 32) v = v & ((32'd1 << VALUE_WIDTH) - 1);
      nd = 0;
      do begin
        digs[nd] = 4'(v % 10);
        v = v / 10;
        nd++;
      end while (v != 0);
      need = nd + 1;
      r.needed_size = 4'(need);
      if (need > it.buffer_size) begin
        r.char_code = u2da_pkg::ASCII_NUL;
        r.position  = '0;
        r.fits      = 1'b0;
        r.last      = 1'b1;
        pending_chars.push_back(r);
        return;
      end
      r.fits = 1'b1;
      r.last = 1'b0;
      for (int i = 0; i < nd; i++) begin
        r.char_code = u2da_pkg::ASCII_ZERO + 8'(digs[nd - 1 - i]);
        r.position  = 4'(i);
        pending_chars.push_back(r);
      end
      r.char_code = u2da_pkg::ASCII_NUL;
      r.position  = 4'(nd);
      r.last      = 1'b1;
      pending_chars.push_back(r);
    endfunction

    task check_char(u2da_pkg::out_item_t got);
      u2da_pkg::out_item_t want;
      if (pending_chars.size() == 0) begin
        report($sformatf("unexpected beat char %0d pos %0d", got.char_code, got.position));
        return;
      end
      want = pending_chars.pop_front();
      if (got.char_code !== want.char_code)
        report($sformatf("char_code %0d, want %0d", got.char_code, want.char_code));
      if (got.position !== want.position)
        report($sformatf("position %0d, want %0d", got.position, want.position));
      if (got.fits !== want.fits)
        report($sformatf("fits %0b, want %0b", got.fits, want.fits));
      if (got.needed_size !== want.needed_size)
        report($sformatf("needed_size %0d, want %0d", got.needed_size, want.needed_size));
      if (got.last !== want.last)
        report($sformatf("last %0b, want %0b", got.last, want.last));
    endtask
  endclass

  logic clk;
  logic rst;
  bit   no_idle;
  bit   hold_rx;
  int   cycles;
  char_scoreboard sb;

  u2da_stream_if #(.T(u2da_pkg::in_item_t))  din_ch ();
  u2da_stream_if #(.T(u2da_pkg::out_item_t)) dout_ch ();

  unsigned_to_decimal_ascii #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_ch),
    .dout (dout_ch)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // offer one number; valid stays high after the beat unless the next call idles
  task send_number(logic [31:0] v, logic [7:0] size);
    int gap;
    u2da_pkg::in_item_t it;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    it.value = v;
    it.buffer_size = size;
    if (gap > 0) begin
      din_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din_ch.valid <= 1'b1;
    din_ch.data  <= it;
    do @(posedge clk); while (!(din_ch.valid && din_ch.ready));
    sb.note_input(it);
  endtask

  // digit count drawn first so every length shows up often
  function logic [31:0] pick_value();
    int nd;
    longint lo;
    longint hi;
    if ($urandom_range(0, 7) == 0) return $urandom;
    nd = $urandom_range(1, 10);
    lo = 1;
    repeat (nd - 1) lo = lo * 10;
    hi = lo * 10 - 1;
    if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
    if (nd == 1) lo = 0;
    return 32'(lo + longint'({$urandom, $urandom} % 64'(hi - lo + 1)));
  endfunction

  function logic [7:0] pick_size(logic [31:0] v);
    int need;
    need = char_scoreboard::digit_count(v) + 1;
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(0, 255));
      1: return 8'(need - 1);
      2: return 8'(need);
      default: return 8'(need + $urandom_range(0, 20));
    endcase
  endfunction

  task wait_drained();
    din_ch.valid <= 1'b0;
    while (sb.pending_chars.size() != 0) @(posedge clk);
  endtask

  // receiver side
  initial begin
    int stall;
    dout_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_rx) begin
        hold_rx = 1'b0;
        stall = LONG_HOLD;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (stall > 0) begin
        dout_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      dout_ch.ready <= 1'b1;
      do @(posedge clk); while (!(dout_ch.valid && dout_ch.ready));
      sb.check_char(dout_ch.data);
    end
  end

  initial begin
    logic [31:0] v;
    sb = new();
    rst = 1'b1;
    no_idle = 1'b0;
    hold_rx = 1'b0;
    din_ch.valid <= 1'b0;
    din_ch.data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero, single digit, digit count boundaries, exact fit and too small
    send_number(32'd0, 8'd2);
    send_number(32'd0, 8'd1);
    send_number(32'd0, 8'd0);
    send_number(32'd0, 8'd255);
    send_number(32'd9, 8'd2);
    send_number(32'd10, 8'd2);
    send_number(32'd10, 8'd3);
    send_number(32'd99, 8'd3);
    send_number(32'd100, 8'd4);
    send_number(32'd12345, 8'd6);
    send_number(32'd999999999, 8'd10);
    send_number(32'd1000000000, 8'd11);
    send_number(32'hFFFF_FFFF, 8'd11);
    send_number(32'hFFFF_FFFF, 8'd10);
    send_number(32'hFFFF_FFFF, 8'd255);
    send_number(32'h8000_0000, 8'd12);
    send_number(32'h5555_5555, 8'd200);
    send_number(32'hAAAA_AAAA, 8'd128);
    send_number(32'd1, 8'd1);
    send_number(32'd7, 8'd127);
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 0) no_idle = 1'b1;
      if (i == 25) no_idle = 1'b0;
      // receiver stops for a long stretch while numbers keep coming
      if (i == 50) hold_rx = 1'b1;
      if (i == 75) wait_drained();
      v = pick_value();
      send_number(v, pick_size(v));
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.pending_chars.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
